// ===== design/hs_pkg.sv =====
// Package for the heap sorter: sizes, port word types, microcode types and the
// microcode program itself. Used by hs_datapath and heap_sorter; depends on nothing.
package hs_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int CHILD_W    = ADDR_W + 2;
    localparam int UPC_W      = 4;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         is_last;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sorted_value;
        logic                         last_out;
        logic                         overflow;
    } out_word_t;

    // Datapath actions, one per microcode step.
    typedef enum logic [3:0] {
        A_NOP,
        A_LOAD,
        A_INIT,
        A_BTEST,
        A_BLOAD,
        A_SREAD,
        A_SCMP,
        A_SDONE,
        A_XNEXT,
        A_XTEST,
        A_XSWAP,
        A_EMSET,
        A_EMRD,
        A_EMOUT,
        A_CLEAR
    } act_t;

    // Jump conditions. When the condition holds the sequencer goes to the
    // target step, otherwise to the following step. C_WAIT holds instead.
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_WAIT,
        C_LEN_LT2,
        C_I_ZERO,
        C_NO_LEFT,
        C_DESCEND,
        C_PHASE_BUILD,
        C_END_ZERO,
        C_MORE_OUT
    } cond_t;

    typedef struct packed {
        act_t             act;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic len_lt2;
        logic i_zero;
        logic no_left;
        logic descend;
        logic phase_build;
        logic end_zero;
        logic more_out;
    } stat_t;

    localparam logic [UPC_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [UPC_W-1:0] STEP_INIT  = 4'd1;
    localparam logic [UPC_W-1:0] STEP_BTEST = 4'd2;
    localparam logic [UPC_W-1:0] STEP_BLOAD = 4'd3;
    localparam logic [UPC_W-1:0] STEP_SREAD = 4'd4;
    localparam logic [UPC_W-1:0] STEP_SCMP  = 4'd5;
    localparam logic [UPC_W-1:0] STEP_SDONE = 4'd6;
    localparam logic [UPC_W-1:0] STEP_XNEXT = 4'd7;
    localparam logic [UPC_W-1:0] STEP_XTEST = 4'd8;
    localparam logic [UPC_W-1:0] STEP_XSWAP = 4'd9;
    localparam logic [UPC_W-1:0] STEP_EMSET = 4'd10;
    localparam logic [UPC_W-1:0] STEP_EMRD  = 4'd11;
    localparam logic [UPC_W-1:0] STEP_EMOUT = 4'd12;
    localparam logic [UPC_W-1:0] STEP_CLEAR = 4'd13;

    // The microcode program.
    function automatic ctrl_t ucode(input logic [UPC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            STEP_IDLE:  w = '{act: A_LOAD,  cond: C_WAIT,        target: STEP_INIT};
            STEP_INIT:  w = '{act: A_INIT,  cond: C_LEN_LT2,     target: STEP_EMSET};
            STEP_BTEST: w = '{act: A_BTEST, cond: C_I_ZERO,      target: STEP_XNEXT};
            STEP_BLOAD: w = '{act: A_BLOAD, cond: C_NEXT,        target: STEP_SREAD};
            STEP_SREAD: w = '{act: A_SREAD, cond: C_NO_LEFT,     target: STEP_SDONE};
            STEP_SCMP:  w = '{act: A_SCMP,  cond: C_DESCEND,     target: STEP_SREAD};
            STEP_SDONE: w = '{act: A_SDONE, cond: C_PHASE_BUILD, target: STEP_BTEST};
            STEP_XNEXT: w = '{act: A_XNEXT, cond: C_NEXT,        target: STEP_XTEST};
            STEP_XTEST: w = '{act: A_XTEST, cond: C_END_ZERO,    target: STEP_EMSET};
            STEP_XSWAP: w = '{act: A_XSWAP, cond: C_ALWAYS,      target: STEP_SREAD};
            STEP_EMSET: w = '{act: A_EMSET, cond: C_NEXT,        target: STEP_EMRD};
            STEP_EMRD:  w = '{act: A_EMRD,  cond: C_NEXT,        target: STEP_EMOUT};
            STEP_EMOUT: w = '{act: A_EMOUT, cond: C_MORE_OUT,    target: STEP_EMRD};
            STEP_CLEAR: w = '{act: A_CLEAR, cond: C_ALWAYS,      target: STEP_IDLE};
            default:    w = '{act: A_NOP,   cond: C_ALWAYS,      target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== design/hs_datapath.sv =====
// Datapath of the heap sorter: element memory, sift registers and comparators.
// Driven by one control word per cycle; depends on hs_pkg.
module hs_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  hs_pkg::ctrl_t    ctrl,
    input  logic             load_en,
    input  hs_pkg::in_word_t item,
    output hs_pkg::stat_t    stat,
    output hs_pkg::out_word_t result
);

    logic signed [hs_pkg::DATA_WIDTH-1:0] heap_mem [hs_pkg::MAX_ITEMS];

    logic [hs_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                      drop_reg, drop_next;
    logic                      phase_reg, phase_next;
    logic [hs_pkg::CNT_W-1:0]  i_reg, i_next;
    logic [hs_pkg::CNT_W-1:0]  len_reg, len_next;
    logic [hs_pkg::ADDR_W-1:0] node_reg, node_next;
    logic signed [hs_pkg::DATA_WIDTH-1:0] val_reg, val_next;
    logic signed [hs_pkg::DATA_WIDTH-1:0] rd_a_reg, rd_b_reg;

    logic [hs_pkg::CHILD_W-1:0] left_idx, right_idx, len_ext;
    logic [hs_pkg::CNT_W-1:0]   i_dec, node_plus1;
    logic                       pick_right, descend;
    logic signed [hs_pkg::DATA_WIDTH-1:0] child_val;
    logic [hs_pkg::ADDR_W-1:0]  child_addr;

    logic                       wr_en;
    logic [hs_pkg::ADDR_W-1:0]  wr_addr, rd_addr_a, rd_addr_b;
    logic signed [hs_pkg::DATA_WIDTH-1:0] wr_data;

    assign left_idx   = hs_pkg::CHILD_W'({node_reg, 1'b1});
    assign right_idx  = left_idx + hs_pkg::CHILD_W'(1);
    assign len_ext    = hs_pkg::CHILD_W'(len_reg);
    assign i_dec      = i_reg - hs_pkg::CNT_W'(1);
    assign node_plus1 = hs_pkg::CNT_W'(node_reg) + hs_pkg::CNT_W'(1);

    // Larger child; the left one wins a tie.
    assign pick_right = (right_idx < len_ext) && (rd_b_reg > rd_a_reg);
    assign child_val  = pick_right ? rd_b_reg : rd_a_reg;
    assign child_addr = pick_right ? right_idx[hs_pkg::ADDR_W-1:0]
                                   : left_idx[hs_pkg::ADDR_W-1:0];
    assign descend    = child_val > val_reg;

    assign stat.len_lt2     = count_reg < hs_pkg::CNT_W'(2);
    assign stat.i_zero      = i_reg == '0;
    assign stat.no_left     = left_idx >= len_ext;
    assign stat.descend     = descend;
    assign stat.phase_build = phase_reg;
    assign stat.end_zero    = len_reg == '0;
    assign stat.more_out    = node_plus1 != count_reg;

    assign result.sorted_value = rd_a_reg;
    assign result.last_out     = node_plus1 == count_reg;
    assign result.overflow     = drop_reg;

    always_comb
    begin
        rd_addr_a = node_reg;
        rd_addr_b = node_reg;
        case (ctrl.act)
            hs_pkg::A_BTEST: rd_addr_a = i_dec[hs_pkg::ADDR_W-1:0];
            hs_pkg::A_SREAD:
            begin
                rd_addr_a = left_idx[hs_pkg::ADDR_W-1:0];
                rd_addr_b = right_idx[hs_pkg::ADDR_W-1:0];
            end
            hs_pkg::A_XTEST:
            begin
                rd_addr_a = '0;
                rd_addr_b = len_reg[hs_pkg::ADDR_W-1:0];
            end
            default: rd_addr_a = node_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = node_reg;
        wr_data = val_reg;
        case (ctrl.act)
            hs_pkg::A_LOAD:
            begin
                wr_en   = load_en && (count_reg < hs_pkg::CNT_W'(hs_pkg::MAX_ITEMS));
                wr_addr = count_reg[hs_pkg::ADDR_W-1:0];
                wr_data = item.value;
            end
            hs_pkg::A_SCMP:
            begin
                wr_en   = descend;
                wr_data = child_val;
            end
            hs_pkg::A_SDONE: wr_en = 1'b1;
            hs_pkg::A_XSWAP:
            begin
                wr_en   = 1'b1;
                wr_addr = len_reg[hs_pkg::ADDR_W-1:0];
                wr_data = rd_a_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        phase_next = phase_reg;
        i_next     = i_reg;
        len_next   = len_reg;
        node_next  = node_reg;
        val_next   = val_reg;
        case (ctrl.act)
            hs_pkg::A_LOAD:
            begin
                if (load_en)
                begin
                    if (count_reg < hs_pkg::CNT_W'(hs_pkg::MAX_ITEMS))
                    begin
                        count_next = count_reg + hs_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
            end
            hs_pkg::A_INIT:
            begin
                i_next     = count_reg >> 1;
                len_next   = count_reg;
                phase_next = 1'b1;
            end
            hs_pkg::A_BTEST:
            begin
                if (i_reg == '0)
                begin
                    phase_next = 1'b0;
                end
                else
                begin
                    i_next    = i_dec;
                    node_next = i_dec[hs_pkg::ADDR_W-1:0];
                end
            end
            hs_pkg::A_BLOAD: val_next = rd_a_reg;
            hs_pkg::A_SCMP:
            begin
                if (descend)
                begin
                    node_next = child_addr;
                end
            end
            hs_pkg::A_XNEXT: len_next = len_reg - hs_pkg::CNT_W'(1);
            hs_pkg::A_XSWAP:
            begin
                val_next  = rd_b_reg;
                node_next = '0;
            end
            hs_pkg::A_EMSET: node_next = '0;
            hs_pkg::A_EMOUT: node_next = node_reg + hs_pkg::ADDR_W'(1);
            hs_pkg::A_CLEAR:
            begin
                count_next = '0;
                drop_next  = 1'b0;
            end
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        len_reg  <= len_next;
        node_reg <= node_next;
        val_reg  <= val_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= heap_mem[rd_addr_a];
        rd_b_reg <= heap_mem[rd_addr_b];
    end

endmodule

// ===== design/heap_sorter.sv =====
// Top level of the heap sorter: microcode sequencer around hs_datapath.
// Depends on hs_pkg and hs_datapath.

// The block takes a batch of signed words, one per cycle, while busy is low:
// a word is taken at a clock edge where start is high and busy is low, and the
// word with is_last set closes the batch. Up to 64 words are kept; words beyond
// that are dropped and every result of the batch then has overflow set. After
// the closing word, busy goes high while the block heap-sorts the batch in its
// single-port-write, dual-port-read memory and then presents the words in
// ascending order, one per strobe cycle, with last_out on the final one. The
// receiver cannot hold results off, so each result must be captured in the
// cycle its strobe is high. The sort is run by a microcode sequencer that
// executes one step per cycle, holding in the idle step until the closing word
// arrives; each level of a sift-down costs two steps (read both children,
// compare and move), the last level of a sift one or two, each heap build node
// three extra steps and each extraction four extra steps. Each result takes a
// read step and an output step. After the strobe of the last result, busy
// stays high through the clear step and then returns low.
module heap_sorter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  hs_pkg::in_word_t  item,
    output logic              busy,
    output logic              strobe,
    output hs_pkg::out_word_t result
);

    logic [hs_pkg::UPC_W-1:0] upc_reg, upc_next;
    hs_pkg::ctrl_t            cw;
    hs_pkg::stat_t            stat;
    logic                     accept;
    logic                     take_jump;

    // The control word for the current step comes straight from the program.
    assign cw     = hs_pkg::ucode(upc_reg);
    assign accept = start && !busy;

    hs_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cw),
        .load_en (accept),
        .item    (item),
        .stat    (stat),
        .result  (result)
    );

    // Next step: evaluate the jump condition of the current control word.
    always_comb
    begin
        take_jump = 1'b0;
        case (cw.cond)
            hs_pkg::C_NEXT:        take_jump = 1'b0;
            hs_pkg::C_ALWAYS:      take_jump = 1'b1;
            hs_pkg::C_WAIT:        take_jump = accept && item.is_last;
            hs_pkg::C_LEN_LT2:     take_jump = stat.len_lt2;
            hs_pkg::C_I_ZERO:      take_jump = stat.i_zero;
            hs_pkg::C_NO_LEFT:     take_jump = stat.no_left;
            hs_pkg::C_DESCEND:     take_jump = stat.descend;
            hs_pkg::C_PHASE_BUILD: take_jump = stat.phase_build;
            hs_pkg::C_END_ZERO:    take_jump = stat.end_zero;
            hs_pkg::C_MORE_OUT:    take_jump = stat.more_out;
            default:               take_jump = 1'b1;
        endcase

        if (take_jump)
        begin
            upc_next = cw.target;
        end
        else if (cw.cond == hs_pkg::C_WAIT)
        begin
            // The idle step holds until the closing word arrives.
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = upc_reg + hs_pkg::UPC_W'(1);
        end
    end

    // Outputs of the sequencer.
    always_comb
    begin
        busy   = upc_reg != hs_pkg::STEP_IDLE;
        strobe = cw.act == hs_pkg::A_EMOUT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= hs_pkg::STEP_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

`ifndef SYNTHESIS
    // Results only appear while a batch is being sorted and drained.
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result strobe while idle");

    // A closing word always starts the sort.
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.is_last) |=> busy)
        else $error("closing word did not start the sort");

    // After the final result the block clears and goes idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last_out) |=> (!strobe ##1 !busy))
        else $error("block did not return to idle after the final result");

    // The step counter never leaves the program.
    a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg <= hs_pkg::STEP_CLEAR)
        else $error("step counter outside the program");
`endif

endmodule
